### rtl/swcs_pkg.sv
// ----------------------------------------------------------------------------
// swcs_pkg
// Shared types, constants and saturation helpers for the sliding-window
// conditional sampler.
// ----------------------------------------------------------------------------
package swcs_pkg;

  // Default sizes of the block.
  localparam int TAGS_DEF      = 4096;
  localparam int WINDOW_DEF    = 32;
  localparam int SECTIONS_DEF  = 16;
  localparam int FRAC_BITS_DEF = 24;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_COEF    = 2'd0,
    OP_SECTION = 2'd1,
    OP_STD     = 2'd2,
    OP_SAMPLE  = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TAG_COUNT  = 2'd0;
  localparam logic [1:0] CFG_WINDOW_LEN = 2'd1;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // Clamp a wide signed value into 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX) begin
      return 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // True when sat32 would clamp the value.
  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > S32_MAX) || (v < S32_MIN);
  endfunction

endpackage

### rtl/swcs_ram.sv
// ----------------------------------------------------------------------------
// swcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/swcs_mul.sv
// ----------------------------------------------------------------------------
// swcs_mul
// Shared fixed-point multiplier: exact 32x32 product, rounded to the
// fraction width by adding half an LSB and flooring, registered.
// ----------------------------------------------------------------------------
module swcs_mul
  import swcs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0] prod_r;

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    prod_r <= (64'(a) * 64'(b) + HALF) >>> FRAC_BITS;
  end

  assign prod = prod_r;

endmodule

### rtl/swcs_div.sv
// ----------------------------------------------------------------------------
// swcs_div
// Radix-2 restoring divider: (num << FRAC_BITS) / den on magnitudes,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swcs_div
  import swcs_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int QW = 32 + FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   num,
  input  logic [31:0]   den,
  output logic          done,
  output logic [QW-1:0] quo
);

  localparam int CNTW = $clog2(QW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [QW-1:0]   sh_r;
  logic [31:0]     rem_r;
  logic [31:0]     den_r;
  logic [32:0]     rem_sh;
  logic            fits;

  // Bring down the next dividend bit and try the subtraction.
  assign rem_sh = {rem_r, sh_r[QW-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the shift register holds the dividend, then the quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= {num, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      sh_r  <= {sh_r[QW-2:0], fits};
      rem_r <= fits ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
    end
  end

  assign done = done_r;
  assign quo  = sh_r;

endmodule

### rtl/sliding_window_conditional_sampler_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_conditional_sampler_unit
// Per-tag autoregressive sampler with piecewise-linear shaping and a
// running maximum of the shaped magnitude.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the in_ channel (valid/ready). Load items (coefficient,
// section, std and counts) are written in the cycle of their transfer and
// ready stays high. A sample item keeps in_ready low until it is finished.
// One shared multiplier serves the std term, the window taps and the
// shaping products; a bit-serial divider serves the interpolation slope.
// How long a sample keeps in_ready low grows with the effective window
// length, and, when its side has sections, with each section scanned and
// the final product; when the value falls between two thresholds, the
// divide and the two products that follow add to it.
// The result of the last tag of a run (max_abs, saturated) goes to an
// output register; the block keeps taking items while it waits there.
// A new result waits in the final step of the sample only while an
// earlier one has not been taken by the receiver.
// Reset clears the sequencer, the history, the maximum and the flag, and
// loads tag_count = 4096 and window_len = 32. The coefficient, section,
// std and count tables hold nothing until written.
// ----------------------------------------------------------------------------
module sliding_window_conditional_sampler_unit
  import swcs_pkg::*;
#(
  parameter int TAGS      = TAGS_DEF,
  parameter int WINDOW    = WINDOW_DEF,
  parameter int SECTIONS  = SECTIONS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [11:0]        in_tag,
  input  logic [4:0]         in_slot,
  input  logic               in_side,
  input  logic signed [31:0] in_coef_or_thres,
  input  logic signed [31:0] in_scale_or_std,
  input  logic [4:0]         in_count_neg,
  input  logic [4:0]         in_count_pos,
  input  logic signed [31:0] in_gauss,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [30:0]        out_max_abs,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_wdata
);

  localparam int TAG_AW = (TAGS > 1) ? $clog2(TAGS) : 1;
  localparam int HW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SW     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int KW     = $clog2(WINDOW + 1);
  localparam int CW     = $clog2(SECTIONS + 1);
  localparam int QW     = 32 + FRAC_BITS;

  localparam int COEF_DEPTH = (1 << TAG_AW) * (1 << HW);
  localparam int SEC_DEPTH  = (1 << TAG_AW) * 2 * (1 << SW);
  localparam int TAG_DEPTH  = 1 << TAG_AW;
  localparam int HIST_DEPTH = 1 << HW;

  localparam logic [QW-1:0] Q_POS_MAX = QW'(64'h7FFFFFFF);
  localparam logic [QW-1:0] Q_NEG_MAX = QW'(64'h80000000);

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_WAIT  = 15'b000000000000010,
    ST_MSTD  = 15'b000000000000100,
    ST_TAPS  = 15'b000000000001000,
    ST_RES   = 15'b000000000010000,
    ST_HWR   = 15'b000000000100000,
    ST_SECA  = 15'b000000001000000,
    ST_SECD  = 15'b000000010000000,
    ST_DIVS  = 15'b000000100000000,
    ST_DIVW  = 15'b000001000000000,
    ST_QMUL  = 15'b000010000000000,
    ST_FAC   = 15'b000100000000000,
    ST_FMUL2 = 15'b001000000000000,
    ST_FMUL  = 15'b010000000000000,
    ST_FIN   = 15'b100000000000000
  } state_t;

  // Registers and their next values.
  state_t             state_r, state_nxt;
  logic [TAG_AW-1:0]  tag_r, tag_nxt;
  logic signed [31:0] gauss_r, gauss_nxt;
  logic               last_r, last_nxt;
  logic [KW-1:0]      w_r, w_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [HW-1:0]      ha_r, ha_nxt;
  logic [HW-1:0]      p_r, p_nxt;
  logic               dv_r, dv_nxt;
  logic               hv_r, hv_nxt;
  logic               pv_r, pv_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [31:0] r_r, r_nxt;
  logic               side_r, side_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      l_r, l_nxt;
  logic signed [31:0] tp_r, tp_nxt;
  logic signed [31:0] sp_r, sp_nxt;
  logic signed [31:0] dt_r, dt_nxt;
  logic signed [31:0] ds_r, ds_nxt;
  logic signed [31:0] dx_r, dx_nxt;
  logic signed [31:0] q_r, q_nxt;
  logic signed [31:0] factor_r, factor_nxt;
  logic signed [31:0] f_r, f_nxt;
  logic [30:0]        max_r, max_nxt;
  logic               sat_r, sat_nxt;
  logic [WINDOW-1:0]  valid_r, valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [30:0]        out_max_r, out_max_nxt;
  logic               out_sat_r, out_sat_nxt;
  logic [12:0]        tag_count_r;
  logic [5:0]         window_len_r;

  // Memory ports.
  logic                   coef_we, sec_we, std_we, hist_we;
  logic signed [31:0]     coef_q, thres_q, scale_q, std_q, hist_q;
  logic [CW-1:0]          cneg_q, cpos_q, cneg_wd, cpos_wd;
  logic [TAG_AW-1:0]      in_tag_a;
  logic [TAG_AW+HW-1:0]   coef_waddr, coef_raddr;
  logic [TAG_AW+SW:0]     sec_waddr, sec_raddr;
  logic [HW-1:0]          p_inc;

  // Shared units.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               div_start, div_done;
  logic [QW-1:0]      div_quo;
  logic [31:0]        dt_mag, ds_mag;

  // Combinational helpers.
  logic               tag_ok, issue, neg, first, hit;
  logic signed [31:0] hist_eff, r_sat;
  logic [30:0]        f_abs;
  logic               f_abs_ovf;
  int                 w_eff, tc_eff, ha_start;

  assign in_tag_a   = TAG_AW'(in_tag);
  assign tag_ok     = 32'(in_tag) < TAGS;
  assign coef_waddr = {in_tag_a, HW'(in_slot)};
  assign coef_raddr = {tag_r, k_r[HW-1:0]};
  assign sec_waddr  = {in_tag_a, in_side, SW'(in_slot)};
  assign sec_raddr  = {tag_r, side_r, l_r[SW-1:0]};
  assign p_inc      = (32'(p_r) == WINDOW - 1) ? '0 : p_r + 1'b1;
  assign cneg_wd    = (32'(in_count_neg) > SECTIONS) ? CW'(SECTIONS) : CW'(in_count_neg);
  assign cpos_wd    = (32'(in_count_pos) > SECTIONS) ? CW'(SECTIONS) : CW'(in_count_pos);
  assign hist_eff   = hv_r ? hist_q : 32'sd0;
  assign r_sat      = sat32(acc_r);
  assign neg        = !side_r;
  assign dt_mag     = dt_r[31] ? 32'(-dt_r) : 32'(dt_r);
  assign ds_mag     = ds_r[31] ? 32'(-ds_r) : 32'(ds_r);
  assign f_abs_ovf  = (f_r == 32'sh80000000);
  assign f_abs      = f_abs_ovf ? 31'h7FFFFFFF : (f_r[31] ? 31'(-f_r) : f_r[30:0]);

  // Effective window, run length and first history address of a sample.
  always_comb begin
    w_eff  = (window_len_r == 6'd0) ? 1 :
             ((32'(window_len_r) > WINDOW) ? WINDOW : 32'(window_len_r));
    tc_eff = (tag_count_r == 13'd0) ? 1 :
             ((32'(tag_count_r) > TAGS) ? TAGS : 32'(tag_count_r));
    ha_start = 32'(p_r) + WINDOW - (w_eff - 1);
    if (ha_start >= WINDOW) begin
      ha_start = ha_start - WINDOW;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_r)
      ST_MSTD: begin
        mul_a = std_q;
        mul_b = gauss_r;
      end
      ST_TAPS: begin
        mul_a = coef_q;
        mul_b = hist_eff;
      end
      ST_SECD: begin
        mul_a = r_r;
        mul_b = scale_q;
      end
      ST_QMUL: begin
        mul_a = q_r;
        mul_b = dx_r;
      end
      ST_FMUL2: begin
        mul_a = r_r;
        mul_b = factor_r;
      end
      default: begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    tag_nxt       = tag_r;
    gauss_nxt     = gauss_r;
    last_nxt      = last_r;
    w_nxt         = w_r;
    k_nxt         = k_r;
    ha_nxt        = ha_r;
    p_nxt         = p_r;
    dv_nxt        = 1'b0;
    hv_nxt        = hv_r;
    pv_nxt        = 1'b0;
    acc_nxt       = acc_r;
    r_nxt         = r_r;
    side_nxt      = side_r;
    n_nxt         = n_r;
    l_nxt         = l_r;
    tp_nxt        = tp_r;
    sp_nxt        = sp_r;
    dt_nxt        = dt_r;
    ds_nxt        = ds_r;
    dx_nxt        = dx_r;
    q_nxt         = q_r;
    factor_nxt    = factor_r;
    f_nxt         = f_r;
    max_nxt       = max_r;
    sat_nxt       = sat_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_max_nxt   = out_max_r;
    out_sat_nxt   = out_sat_r;
    coef_we       = 1'b0;
    sec_we        = 1'b0;
    std_we        = 1'b0;
    hist_we       = 1'b0;
    div_start     = 1'b0;
    issue         = 1'b0;
    first         = 1'b0;
    hit           = 1'b0;
    in_ready      = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && tag_ok) begin
          unique case (op_t'(in_op))
            OP_COEF: coef_we = 32'(in_slot) < WINDOW;
            OP_SECTION: sec_we = 32'(in_slot) < SECTIONS;
            OP_STD: std_we = 1'b1;
            OP_SAMPLE: begin
              tag_nxt   = in_tag_a;
              gauss_nxt = in_gauss;
              last_nxt  = 32'(in_tag) == tc_eff - 1;
              w_nxt     = KW'(w_eff);
              k_nxt     = '0;
              ha_nxt    = HW'(ha_start);
              acc_nxt   = 64'sd0;
              if (in_tag == 12'd0) begin
                valid_nxt = '0;
                max_nxt   = '0;
                sat_nxt   = 1'b0;
              end
              state_nxt = ST_WAIT;
            end
            default: ;
          endcase
        end
      end
      ST_WAIT: state_nxt = ST_MSTD;
      ST_MSTD: begin
        pv_nxt    = 1'b1;
        state_nxt = ST_TAPS;
      end
      ST_TAPS: begin
        // Read, multiply and accumulate overlap, one tap per cycle.
        issue  = k_r < w_r;
        dv_nxt = issue;
        pv_nxt = dv_r;
        if (issue) begin
          k_nxt  = k_r + 1'b1;
          ha_nxt = (32'(ha_r) == WINDOW - 1) ? '0 : ha_r + 1'b1;
          hv_nxt = valid_r[ha_r];
        end
        if (pv_r) begin
          acc_nxt = acc_r + prod;
        end
        if (!issue && !dv_r && !pv_r) begin
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        r_nxt     = r_sat;
        sat_nxt   = sat_r | ovf32(acc_r);
        side_nxt  = r_sat > 32'sd0;
        state_nxt = ST_HWR;
      end
      ST_HWR: begin
        // Push the result into the history and fetch the side's count.
        hist_we          = 1'b1;
        p_nxt            = p_inc;
        valid_nxt[p_inc] = 1'b1;
        n_nxt            = side_r ? cpos_q : cneg_q;
        l_nxt            = '0;
        if (n_nxt == '0) begin
          f_nxt     = r_r;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SECA;
        end
      end
      ST_SECA: state_nxt = ST_SECD;
      ST_SECD: begin
        first = (l_r == '0);
        if (first) begin
          hit = neg ? (r_r >= thres_q) : (r_r <= thres_q);
        end else begin
          hit = neg ? (r_r > thres_q) : (r_r < thres_q);
        end
        if (hit && first) begin
          state_nxt = ST_FMUL;
        end else if (hit) begin
          dt_nxt    = sat32(64'(thres_q) - 64'(tp_r));
          ds_nxt    = sat32(64'(scale_q) - 64'(sp_r));
          dx_nxt    = sat32(64'(r_r) - 64'(tp_r));
          sat_nxt   = sat_r | ovf32(64'(thres_q) - 64'(tp_r))
                            | ovf32(64'(scale_q) - 64'(sp_r))
                            | ovf32(64'(r_r) - 64'(tp_r));
          state_nxt = ST_DIVS;
        end else if (l_r + 1'b1 == n_r) begin
          state_nxt = ST_FMUL;
        end else begin
          tp_nxt    = thres_q;
          sp_nxt    = scale_q;
          l_nxt     = l_r + 1'b1;
          state_nxt = ST_SECA;
        end
      end
      ST_DIVS: begin
        if (dt_r == 32'sd0) begin
          q_nxt     = 32'sd0;
          state_nxt = ST_QMUL;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIVW;
        end
      end
      ST_DIVW: begin
        // Apply the quotient sign and clamp to 32 bits.
        if (div_done) begin
          if (ds_r[31] ^ dt_r[31]) begin
            if (div_quo > Q_NEG_MAX) begin
              q_nxt   = 32'sh80000000;
              sat_nxt = 1'b1;
            end else begin
              q_nxt = 32'(-div_quo);
            end
          end else begin
            if (div_quo > Q_POS_MAX) begin
              q_nxt   = 32'sh7FFFFFFF;
              sat_nxt = 1'b1;
            end else begin
              q_nxt = 32'(div_quo);
            end
          end
          state_nxt = ST_QMUL;
        end
      end
      ST_QMUL: state_nxt = ST_FAC;
      ST_FAC: begin
        factor_nxt = sat32(64'(sp_r) + prod);
        sat_nxt    = sat_r | ovf32(64'(sp_r) + prod);
        state_nxt  = ST_FMUL2;
      end
      ST_FMUL2: state_nxt = ST_FMUL;
      ST_FMUL: begin
        f_nxt     = sat32(prod);
        sat_nxt   = sat_r | ovf32(prod);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // Update the run maximum; the last tag also loads the output.
        if (!(last_r && out_valid_r && !out_ready)) begin
          max_nxt   = (f_abs > max_r) ? f_abs : max_r;
          sat_nxt   = sat_r | f_abs_ovf;
          if (last_r) begin
            out_valid_nxt = 1'b1;
            out_max_nxt   = max_nxt;
            out_sat_nxt   = sat_nxt;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dv_r         <= 1'b0;
      pv_r         <= 1'b0;
      p_r          <= '0;
      max_r        <= '0;
      sat_r        <= 1'b0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
      tag_count_r  <= 13'd4096;
      window_len_r <= 6'd32;
    end else begin
      state_r     <= state_nxt;
      dv_r        <= dv_nxt;
      pv_r        <= pv_nxt;
      p_r         <= p_nxt;
      max_r       <= max_nxt;
      sat_r       <= sat_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_TAG_COUNT) begin
        tag_count_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_WINDOW_LEN) begin
        window_len_r <= cfg_wdata[5:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    tag_r     <= tag_nxt;
    gauss_r   <= gauss_nxt;
    last_r    <= last_nxt;
    w_r       <= w_nxt;
    k_r       <= k_nxt;
    ha_r      <= ha_nxt;
    hv_r      <= hv_nxt;
    acc_r     <= acc_nxt;
    r_r       <= r_nxt;
    side_r    <= side_nxt;
    n_r       <= n_nxt;
    l_r       <= l_nxt;
    tp_r      <= tp_nxt;
    sp_r      <= sp_nxt;
    dt_r      <= dt_nxt;
    ds_r      <= ds_nxt;
    dx_r      <= dx_nxt;
    q_r       <= q_nxt;
    factor_r  <= factor_nxt;
    f_r       <= f_nxt;
    out_max_r <= out_max_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_max_abs   = out_max_r;
  assign out_saturated = out_sat_r;

  // Tables.
  swcs_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef (
    .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(in_coef_or_thres),
    .raddr(coef_raddr), .rdata(coef_q)
  );

  swcs_ram #(.WIDTH(32), .DEPTH(SEC_DEPTH)) u_thres (
    .clk(clk), .we(sec_we), .waddr(sec_waddr), .wdata(in_coef_or_thres),
    .raddr(sec_raddr), .rdata(thres_q)
  );

  swcs_ram #(.WIDTH(32), .DEPTH(SEC_DEPTH)) u_scale (
    .clk(clk), .we(sec_we), .waddr(sec_waddr), .wdata(in_scale_or_std),
    .raddr(sec_raddr), .rdata(scale_q)
  );

  swcs_ram #(.WIDTH(32), .DEPTH(TAG_DEPTH)) u_std (
    .clk(clk), .we(std_we), .waddr(in_tag_a), .wdata(in_scale_or_std),
    .raddr(tag_r), .rdata(std_q)
  );

  swcs_ram #(.WIDTH(CW), .DEPTH(TAG_DEPTH)) u_cneg (
    .clk(clk), .we(std_we), .waddr(in_tag_a), .wdata(cneg_wd),
    .raddr(tag_r), .rdata(cneg_q)
  );

  swcs_ram #(.WIDTH(CW), .DEPTH(TAG_DEPTH)) u_cpos (
    .clk(clk), .we(std_we), .waddr(in_tag_a), .wdata(cpos_wd),
    .raddr(tag_r), .rdata(cpos_q)
  );

  swcs_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_hist (
    .clk(clk), .we(hist_we), .waddr(p_inc), .wdata(r_r),
    .raddr(ha_r), .rdata(hist_q)
  );

  // Shared arithmetic.
  swcs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .prod(prod)
  );

  swcs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(ds_mag), .den(dt_mag),
    .done(div_done), .quo(div_quo)
  );

endmodule

### rtl/swcs_checker.sv
// ----------------------------------------------------------------------------
// swcs_checker
// Port-level checks of the sampler's handshakes over time.
// ----------------------------------------------------------------------------
module swcs_checker
  import swcs_pkg::*;
#(
  parameter int TAGS = TAGS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_op,
  input logic [11:0] in_tag,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] out_max_abs,
  input logic        out_saturated
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_max_abs) && $stable(out_saturated))
    else $error("result changed while stalled");

  // After a load transfer the block stays ready.
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op != OP_SAMPLE |=> in_ready)
    else $error("ready dropped after a load transfer");

  // A sample occupies the block.
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_SAMPLE && 32'(in_tag) < TAGS |=> !in_ready)
    else $error("ready stayed high during a sample");

  // A new result only appears at the end of a sample.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a sample in progress");

endmodule

bind sliding_window_conditional_sampler_unit swcs_checker #(.TAGS(TAGS)) u_swcs_checker (.*);
